@@ hw/rtl/unsigned_to_ascii_digits_assert.svh @@
// assertion macros shared by the digit formatter rtl
`ifndef UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH
`define UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH

// plain property under the block clock, masked while in reset
`define U2AD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define U2AD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/u2ad_pkg.sv @@
// shared types, constants and functions of the digit formatter
package u2ad_pkg;

  localparam int unsigned MaxDigits = 10;

  // reciprocal of ten, scaled by 2**35, exact for every 32-bit value
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  localparam logic [6:0] AsciiZero  = 7'h30;
  localparam logic [6:0] AsciiLower = 7'h61;
  localparam logic [6:0] AsciiUpper = 7'h41;

  typedef struct packed {
    logic load;   // capture a new number
    logic step;   // one conversion step
    logic emit;   // move one character into the output register
  } cmd_t;

  typedef struct packed {
    logic conv_done;  // last digit is being written this step
    logic emit_last;  // next character out is the least significant one
  } sts_t;

  function automatic logic [6:0] digit_to_ascii(logic [3:0] digit, logic upper);
    logic [6:0] base;
    logic [6:0] code;
    base = upper ? AsciiUpper : AsciiLower;
    if (digit < 4'd10) begin
      code = AsciiZero + {3'b000, digit};
    end else begin
      code = base + {3'b000, digit} - 7'd10;
    end
    return code;
  endfunction

endpackage

@@ hw/rtl/u2ad_ctrl.sv @@
// controller state machine of the digit formatter
`include "unsigned_to_ascii_digits_assert.svh"

module u2ad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  u2ad_pkg::sts_t sts_i,
  output u2ad_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // output register is free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `U2AD_ASSERT(a_emit_slot_free, !cmd_o.emit || !out_valid_q || out_ready_i, "emit overwrote a pending transaction")
  `U2AD_ASSERT_NEXT(a_last_to_idle, cmd_o.emit && sts_i.emit_last, state_q == StIdle, "run did not end after last char")
  `U2AD_ASSERT_NEXT(a_load_to_conv, cmd_o.load, state_q == StConv, "load did not start conversion")

endmodule

@@ hw/rtl/u2ad_datapath.sv @@
// conversion datapath: reciprocal divide, digit buffer and output register
`include "unsigned_to_ascii_digits_assert.svh"

module u2ad_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2ad_pkg::cmd_t cmd_i,
  output u2ad_pkg::sts_t sts_o,
  input  logic [31:0]    value_i,
  input  logic [1:0]     opcode_i,
  output logic [6:0]     char_code_o,
  output logic           last_char_o,
  output logic [3:0]     digit_count_o
);

  logic [31:0] value_q;
  logic [31:0] prev_q;
  logic        hex_q;
  logic        upper_q;
  logic        pending_q;
  logic [3:0]  wr_ptr_q;
  logic [3:0]  rd_ptr_q;
  logic [3:0]  count_q;
  logic [3:0]  digits_q [u2ad_pkg::MaxDigits];
  logic [6:0]  char_q;
  logic        last_q;
  logic [3:0]  out_count_q;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;

  assign prod = {32'h0, value_q} * {32'h0, u2ad_pkg::RecipTen};
  // a 32-bit value over ten fits in 29 bits
  assign quot = hex_q ? {4'h0, value_q[31:4]} : {3'h0, prod[u2ad_pkg::RecipShift +: 29]};

  // remainder is below the radix, so the low nibble of prev - q*radix is enough
  assign rem = hex_q ? prev_q[3:0] : 4'(prev_q[3:0] - 4'(value_q[3:0] * 4'd10));

  assign sts_o.conv_done = pending_q && (value_q == 32'h0);
  assign sts_o.emit_last = (rd_ptr_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        pending_q <= 1'b0;
        wr_ptr_q  <= '0;
      end else if (cmd_i.step) begin
        pending_q <= 1'b1;
        if (pending_q) begin
          wr_ptr_q <= wr_ptr_q + 4'd1;
          if (sts_o.conv_done) begin
            rd_ptr_q <= wr_ptr_q;
          end
        end
      end else if (cmd_i.emit && !sts_o.emit_last) begin
        rd_ptr_q <= rd_ptr_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      hex_q   <= |opcode_i;
      upper_q <= opcode_i[1];
    end else if (cmd_i.step) begin
      value_q <= quot;
      prev_q  <= value_q;
      if (pending_q) begin
        digits_q[wr_ptr_q] <= rem;
        if (sts_o.conv_done) begin
          count_q <= wr_ptr_q + 4'd1;
        end
      end
    end
    if (cmd_i.emit) begin
      char_q      <= u2ad_pkg::digit_to_ascii(digits_q[rd_ptr_q], upper_q);
      last_q      <= sts_o.emit_last;
      out_count_q <= count_q;
    end
  end

  assign char_code_o   = char_q;
  assign last_char_o   = last_q;
  assign digit_count_o = out_count_q;

  `U2AD_ASSERT(a_wr_ptr_range, wr_ptr_q <= 4'(u2ad_pkg::MaxDigits), "digit buffer overrun")
  `U2AD_ASSERT(a_rd_ptr_range, rd_ptr_q < 4'(u2ad_pkg::MaxDigits), "read pointer out of range")
  `U2AD_ASSERT(a_no_mixed_cmd, $onehot0({cmd_i.load, cmd_i.step, cmd_i.emit}), "overlapping commands")

endmodule

@@ hw/rtl/unsigned_to_ascii_digits.sv @@
// Unsigned 32-bit number to ASCII digits, decimal or lower/upper-case hex, most significant
// digit first with leading zeros dropped (zero gives a single '0'). Each output transaction is
// one character with a last-of-run flag and the run's total digit count. One number is
// handled at a time: after the input transaction the converter produces the number's digits
// (one reciprocal multiply by 1/10, or a 4-bit shift for hex, per cycle) into a small digit
// buffer, then emits one character per cycle while the output is not stalled, through a
// single output register. Input ready is high only between runs.
module unsigned_to_ascii_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [1:0]  opcode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_code_o,
  output logic        last_char_o,
  output logic [3:0]  digit_count_o
);

  u2ad_pkg::cmd_t cmd;
  u2ad_pkg::sts_t sts;

  u2ad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u2ad_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .opcode_i      (opcode_i),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o),
    .digit_count_o (digit_count_o)
  );

endmodule
